[hdl/pmosl_pkg.sv]
// ----------------------------------------------------------------------------
// Pair momentum out/side/long package
// Shared widths, latencies, payload types and saturation helpers.
// ----------------------------------------------------------------------------
package pmosl_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int ENERGY_W    = 31;
    localparam int MOM_W       = 32;
    localparam int SUM_W       = ENERGY_W + 2;
    localparam int SQ_W        = 64;
    localparam int ROOT_W      = SQ_W / 2;
    localparam int SQ_REM_W    = ROOT_W + 3;
    localparam int NUMER_W     = 2 * SUM_W + 2;
    localparam int NUM_W       = 100;
    localparam int DEN_W       = ROOT_W + 1;
    localparam int Q_W         = 64;
    localparam int REM_W       = DEN_W + 1;
    localparam int PR_W        = REM_W + Q_W;

    localparam int FRONT_LAT  = 4;
    localparam int SQRT_LAT   = ROOT_W;
    localparam int DIV_LAT    = Q_W + 1;
    localparam int RECOMB_LAT = 4;
    localparam int PIPE_LAT   = FRONT_LAT + SQRT_LAT + DIV_LAT + RECOMB_LAT + DIV_LAT + 1;

    localparam logic [Q_W-1:0] LIM_Q  = {{(Q_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [Q_W-1:0] LIMN_Q = {{(Q_W-VALUE_WIDTH){1'b0}}, 1'b1,
                                         {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [Q_W-1:0] BIG_Q  = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] BIGN_Q = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_LONG    = 2'd1,
        STAT_ZERO_PT = 2'd2,
        STAT_TRANS   = 2'd3
    } status_t;

    typedef struct packed {
        logic        [ENERGY_W-1:0] a_energy;
        logic signed [MOM_W-1:0]    a_px;
        logic signed [MOM_W-1:0]    a_py;
        logic signed [MOM_W-1:0]    a_pz;
        logic        [ENERGY_W-1:0] b_energy;
        logic signed [MOM_W-1:0]    b_px;
        logic signed [MOM_W-1:0]    b_py;
        logic signed [MOM_W-1:0]    b_pz;
    } in_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] out_component;
        logic signed [VALUE_WIDTH-1:0] side_component;
        logic signed [VALUE_WIDTH-1:0] long_component;
        status_t                       status;
    } out_t;

    typedef struct packed {
        logic signed [NUMER_W-1:0] nl;
        logic signed [NUMER_W-1:0] ns;
        logic signed [NUMER_W-1:0] no;
        logic signed [NUMER_W-1:0] ne;
        logic        [SQ_W-1:0]    ml2;
        logic        [SQ_W-1:0]    pt2;
        logic        [SQ_W-1:0]    mm2;
        status_t                   status;
    } front_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic        [DEN_W-1:0] den;
    } div_in_t;

    typedef struct packed {
        logic           neg;
        logic           ovf;
        logic [Q_W-1:0] q;
    } div_res_t;

    typedef struct packed {
        logic           neg;
        logic [Q_W-1:0] mag;
    } smag_t;

    typedef struct packed {
        div_res_t            lng;
        div_res_t            side;
        div_res_t            o;
        div_res_t            e;
        logic [ROOT_W-1:0]   ml;
        logic [ROOT_W-1:0]   pt;
        logic [ROOT_W-1:0]   m;
        status_t             status;
    } rc_in_t;

    typedef struct packed {
        logic signed [NUM_W-1:0]       num;
        logic        [DEN_W-1:0]       den;
        logic signed [VALUE_WIDTH-1:0] lng;
        logic signed [VALUE_WIDTH-1:0] side;
        status_t                       status;
    } rc_out_t;

    function automatic logic [VALUE_WIDTH-1:0] sat_val(input div_res_t r);
        logic [VALUE_WIDTH-1:0] v;
        if (!r.neg) begin
            if (r.ovf || r.q > LIM_Q) begin
                v = VMAX;
            end else begin
                v = r.q[VALUE_WIDTH-1:0];
            end
        end else begin
            if (r.ovf || r.q > LIMN_Q) begin
                v = VMIN;
            end else begin
                v = ~r.q[VALUE_WIDTH-1:0] + 1'b1;
            end
        end
        return v;
    endfunction

    function automatic smag_t sat_big(input div_res_t r);
        smag_t s;
        s.neg = r.neg;
        if (!r.neg) begin
            s.mag = (r.ovf || r.q > BIG_Q) ? BIG_Q : r.q;
        end else begin
            s.mag = (r.ovf || r.q > BIGN_Q) ? BIGN_Q : r.q;
        end
        return s;
    endfunction

endpackage

[hdl/pmosl_front.sv]
// ----------------------------------------------------------------------------
// Pair momentum front end
// Sums, differences, squares and cross products of the two four-momenta,
// and the status of the pair, in four register stages.
// ----------------------------------------------------------------------------
module pmosl_front (
    input  logic              aclk,
    input  logic              en,
    input  pmosl_pkg::in_t    din,
    output pmosl_pkg::front_t dout
);
    import pmosl_pkg::*;

    localparam int PROD_W = 2 * SUM_W;
    localparam int PT2_W  = PROD_W + 1;

    logic [SUM_W-1:0] se_next, absz_next, mx_next, my_next;
    logic signed [SUM_W-1:0] sx_next, sy_next, sz_next;
    logic signed [SUM_W-1:0] d0_next, d1_next, d2_next, d3_next;

    logic [SUM_W-1:0] se_reg, absz_reg, mx_reg, my_reg;
    logic signed [SUM_W-1:0] sz_reg, sx_reg, sy_reg;
    logic signed [SUM_W-1:0] d0_reg, d1_reg, d2_reg, d3_reg;
    logic s1_long_reg, s1_zero_reg;

    logic [SQ_W-1:0] se2_reg;
    logic [PROD_W-1:0] sz2_reg, sx2_reg, sy2_reg;
    logic signed [PROD_W-1:0] p_sed3_reg, p_szd0_reg, p_d2sx_reg, p_d1sy_reg;
    logic signed [PROD_W-1:0] p_d1sx_reg, p_d2sy_reg, p_sed0_reg, p_szd3_reg;
    logic s2_long_reg, s2_zero_reg;

    logic [SQ_W-1:0] ml2_reg;
    logic [PT2_W-1:0] pt2_reg;
    logic signed [NUMER_W-1:0] nl_reg, ns_reg, no_reg, ne_reg;
    logic s3_long_reg, s3_zero_reg;

    front_t dout_next, dout_reg;

    always_comb begin
        se_next = {2'b00, din.a_energy} + {2'b00, din.b_energy};
        d0_next = $signed({2'b00, din.a_energy}) - $signed({2'b00, din.b_energy});
        d1_next = $signed({din.a_px[MOM_W-1], din.a_px}) - $signed({din.b_px[MOM_W-1], din.b_px});
        d2_next = $signed({din.a_py[MOM_W-1], din.a_py}) - $signed({din.b_py[MOM_W-1], din.b_py});
        d3_next = $signed({din.a_pz[MOM_W-1], din.a_pz}) - $signed({din.b_pz[MOM_W-1], din.b_pz});
        sx_next = $signed({din.a_px[MOM_W-1], din.a_px}) + $signed({din.b_px[MOM_W-1], din.b_px});
        sy_next = $signed({din.a_py[MOM_W-1], din.a_py}) + $signed({din.b_py[MOM_W-1], din.b_py});
        sz_next = $signed({din.a_pz[MOM_W-1], din.a_pz}) + $signed({din.b_pz[MOM_W-1], din.b_pz});
        absz_next = sz_next[SUM_W-1] ? (~sz_next + 1'b1) : sz_next;
        mx_next   = sx_next[SUM_W-1] ? (~sx_next + 1'b1) : sx_next;
        my_next   = sy_next[SUM_W-1] ? (~sy_next + 1'b1) : sy_next;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            se_reg      <= se_next;
            absz_reg    <= absz_next;
            mx_reg      <= mx_next;
            my_reg      <= my_next;
            sx_reg      <= sx_next;
            sy_reg      <= sy_next;
            sz_reg      <= sz_next;
            d0_reg      <= d0_next;
            d1_reg      <= d1_next;
            d2_reg      <= d2_next;
            d3_reg      <= d3_next;
            s1_long_reg <= (absz_next >= se_next);
            s1_zero_reg <= (sx_next == '0) && (sy_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            se2_reg     <= se_reg[SUM_W-2:0] * se_reg[SUM_W-2:0];
            sz2_reg     <= absz_reg * absz_reg;
            sx2_reg     <= mx_reg * mx_reg;
            sy2_reg     <= my_reg * my_reg;
            p_sed3_reg  <= $signed(se_reg) * d3_reg;
            p_szd0_reg  <= sz_reg * d0_reg;
            p_d2sx_reg  <= d2_reg * sx_reg;
            p_d1sy_reg  <= d1_reg * sy_reg;
            p_d1sx_reg  <= d1_reg * sx_reg;
            p_d2sy_reg  <= d2_reg * sy_reg;
            p_sed0_reg  <= $signed(se_reg) * d0_reg;
            p_szd3_reg  <= sz_reg * d3_reg;
            s2_long_reg <= s1_long_reg;
            s2_zero_reg <= s1_zero_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ml2_reg     <= se2_reg - sz2_reg[SQ_W-1:0];
            pt2_reg     <= PT2_W'(sx2_reg) + PT2_W'(sy2_reg);
            nl_reg      <= NUMER_W'(p_sed3_reg) - NUMER_W'(p_szd0_reg);
            ns_reg      <= NUMER_W'(p_d2sx_reg) - NUMER_W'(p_d1sy_reg);
            no_reg      <= NUMER_W'(p_d1sx_reg) + NUMER_W'(p_d2sy_reg);
            ne_reg      <= NUMER_W'(p_sed0_reg) - NUMER_W'(p_szd3_reg);
            s3_long_reg <= s2_long_reg;
            s3_zero_reg <= s2_zero_reg;
        end
    end

    always_comb begin
        dout_next.nl  = nl_reg;
        dout_next.ns  = ns_reg;
        dout_next.no  = no_reg;
        dout_next.ne  = ne_reg;
        dout_next.ml2 = ml2_reg;
        dout_next.pt2 = pt2_reg[SQ_W-1:0];
        dout_next.mm2 = ml2_reg - pt2_reg[SQ_W-1:0];
        if (s3_long_reg) begin
            dout_next.status = STAT_LONG;
        end else if (s3_zero_reg) begin
            dout_next.status = STAT_ZERO_PT;
        end else if (pt2_reg >= PT2_W'(ml2_reg)) begin
            dout_next.status = STAT_TRANS;
        end else begin
            dout_next.status = STAT_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

[hdl/pmosl_isqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64-bit radicand, two radicand bits per stage.
// ----------------------------------------------------------------------------
module pmosl_isqrt (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [pmosl_pkg::SQ_W-1:0]    x,
    output logic [pmosl_pkg::ROOT_W-1:0]  root
);
    import pmosl_pkg::*;

    logic [SQ_W-1:0]     x_reg    [SQRT_LAT];
    logic [SQ_REM_W-1:0] rem_reg  [SQRT_LAT];
    logic [ROOT_W-1:0]   root_reg [SQRT_LAT];
    logic [SQ_W-1:0]     x_next    [SQRT_LAT];
    logic [SQ_REM_W-1:0] rem_next  [SQRT_LAT];
    logic [ROOT_W-1:0]   root_next [SQRT_LAT];

    always_comb begin
        logic [SQ_W-1:0]     x_in;
        logic [SQ_REM_W-1:0] rem_in;
        logic [ROOT_W-1:0]   root_in;
        logic [SQ_REM_W-1:0] cat;
        logic [SQ_REM_W-1:0] trial;
        for (int i = 0; i < SQRT_LAT; i++) begin
            if (i == 0) begin
                x_in    = x;
                rem_in  = '0;
                root_in = '0;
            end else begin
                x_in    = x_reg[i-1];
                rem_in  = rem_reg[i-1];
                root_in = root_reg[i-1];
            end
            cat   = {rem_in[SQ_REM_W-3:0], x_in[SQ_W-1:SQ_W-2]};
            trial = {1'b0, root_in, 2'b01};
            x_next[i] = {x_in[SQ_W-3:0], 2'b00};
            if (cat >= trial) begin
                rem_next[i]  = cat - trial;
                root_next[i] = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[i]  = cat;
                root_next[i] = {root_in[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < SQRT_LAT; i++) begin
                x_reg[i]    <= x_next[i];
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
            end
        end
    end

    assign root = root_reg[SQRT_LAT-1];

endmodule

[hdl/pmosl_div.sv]
// ----------------------------------------------------------------------------
// Pipelined signed divider
// Signed numerator over unsigned divisor, truncating, one quotient bit per
// stage after the first, with an overflow flag past the quotient width.
// ----------------------------------------------------------------------------
module pmosl_div (
    input  logic                 aclk,
    input  logic                 en,
    input  pmosl_pkg::div_in_t   din,
    output pmosl_pkg::div_res_t  dout
);
    import pmosl_pkg::*;

    logic [PR_W-1:0]  pr_reg  [DIV_LAT];
    logic [DEN_W-1:0] d_reg   [DIV_LAT];
    logic             neg_reg [DIV_LAT];
    logic             ovf_reg [DIV_LAT];
    logic [PR_W-1:0]  pr_next [DIV_LAT];

    logic [NUM_W-1:0] mag;

    always_comb begin
        logic [PR_W-1:0]  sh;
        logic [REM_W-1:0] top;
        mag = din.num[NUM_W-1] ? (~din.num + 1'b1) : din.num;
        pr_next[0] = {1'b0, mag[Q_W+DEN_W-1:0]};
        for (int k = 1; k < DIV_LAT; k++) begin
            sh  = {pr_reg[k-1][PR_W-2:0], 1'b0};
            top = sh[PR_W-1:Q_W];
            if (top >= {1'b0, d_reg[k-1]}) begin
                sh[PR_W-1:Q_W] = top - {1'b0, d_reg[k-1]};
                sh[0] = 1'b1;
            end
            pr_next[k] = sh;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pr_reg[0]  <= pr_next[0];
            d_reg[0]   <= din.den;
            neg_reg[0] <= din.num[NUM_W-1];
            ovf_reg[0] <= mag[NUM_W-1:Q_W] >= {{(NUM_W-Q_W-DEN_W){1'b0}}, din.den};
            for (int k = 1; k < DIV_LAT; k++) begin
                pr_reg[k]  <= pr_next[k];
                d_reg[k]   <= d_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign dout.neg = neg_reg[DIV_LAT-1];
    assign dout.ovf = ovf_reg[DIV_LAT-1];
    assign dout.q   = pr_reg[DIV_LAT-1][Q_W-1:0];

endmodule

[hdl/pmosl_recomb.sv]
// ----------------------------------------------------------------------------
// Out numerator recombination
// Saturates the first divider results and forms ML*o - PT*e from 64-bit
// partial products of 32-bit halves over four register stages.
// ----------------------------------------------------------------------------
module pmosl_recomb (
    input  logic               aclk,
    input  logic               en,
    input  pmosl_pkg::rc_in_t  din,
    output pmosl_pkg::rc_out_t dout
);
    import pmosl_pkg::*;

    localparam int PP_W  = 2 * ROOT_W;
    localparam int PO_W  = ROOT_W + Q_W;

    logic [VALUE_WIDTH-1:0] lng1_reg, side1_reg, lng2_reg, side2_reg, lng3_reg, side3_reg;
    smag_t o1_reg, e1_reg;
    logic [ROOT_W-1:0] ml1_reg, pt1_reg, m1_reg, m2_reg, m3_reg;
    status_t st1_reg, st2_reg, st3_reg;
    logic [PP_W-1:0] mol_reg, moh_reg, pel_reg, peh_reg;
    logic o_neg2_reg, e_neg2_reg, o_neg3_reg, e_neg3_reg;
    logic [PO_W-1:0] po_reg, pe_reg;
    rc_out_t dout_next, dout_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            lng1_reg  <= sat_val(din.lng);
            side1_reg <= sat_val(din.side);
            o1_reg    <= sat_big(din.o);
            e1_reg    <= sat_big(din.e);
            ml1_reg   <= din.ml;
            pt1_reg   <= din.pt;
            m1_reg    <= din.m;
            st1_reg   <= din.status;

            mol_reg    <= o1_reg.mag[ROOT_W-1:0] * ml1_reg;
            moh_reg    <= o1_reg.mag[Q_W-1:ROOT_W] * ml1_reg;
            pel_reg    <= e1_reg.mag[ROOT_W-1:0] * pt1_reg;
            peh_reg    <= e1_reg.mag[Q_W-1:ROOT_W] * pt1_reg;
            o_neg2_reg <= o1_reg.neg;
            e_neg2_reg <= e1_reg.neg;
            lng2_reg   <= lng1_reg;
            side2_reg  <= side1_reg;
            m2_reg     <= m1_reg;
            st2_reg    <= st1_reg;

            po_reg     <= {moh_reg, {ROOT_W{1'b0}}} + PO_W'(mol_reg);
            pe_reg     <= {peh_reg, {ROOT_W{1'b0}}} + PO_W'(pel_reg);
            o_neg3_reg <= o_neg2_reg;
            e_neg3_reg <= e_neg2_reg;
            lng3_reg   <= lng2_reg;
            side3_reg  <= side2_reg;
            m3_reg     <= m2_reg;
            st3_reg    <= st2_reg;

            dout_reg   <= dout_next;
        end
    end

    always_comb begin
        logic signed [NUM_W-1:0] po_s;
        logic signed [NUM_W-1:0] pe_s;
        po_s = $signed(NUM_W'(po_reg));
        pe_s = $signed(NUM_W'(pe_reg));
        if (o_neg3_reg) begin
            po_s = -po_s;
        end
        if (e_neg3_reg) begin
            pe_s = -pe_s;
        end
        dout_next.num    = po_s - pe_s;
        dout_next.den    = {m3_reg, 1'b0};
        dout_next.lng    = lng3_reg;
        dout_next.side   = side3_reg;
        dout_next.status = st3_reg;
    end

    assign dout = dout_reg;

endmodule

[hdl/pair_momentum_out_side_long.sv]
// ----------------------------------------------------------------------------
// Pair momentum out/side/long decomposition
// Takes one particle pair per cycle while s_ready is high and returns its
// out, side and long relative momentum components and a status code. The
// pipeline chain is four front-end product stages, a 32-stage square root
// pipeline, two 65-stage divider pipelines, four recombination stages and
// the result and output registers. The first of these stages loads on the
// accepting edge. An output register with a skid stage decouples the result
// side, so input is taken while a result waits to be read.
// ----------------------------------------------------------------------------
module pair_momentum_out_side_long (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pmosl_pkg::in_t    s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pmosl_pkg::out_t   m_data
);
    import pmosl_pkg::*;

    typedef struct packed {
        logic signed [NUMER_W-1:0] nl;
        logic signed [NUMER_W-1:0] ns;
        logic signed [NUMER_W-1:0] no;
        logic signed [NUMER_W-1:0] ne;
        status_t                   status;
    } p1_t;

    typedef struct packed {
        logic [ROOT_W-1:0] ml;
        logic [ROOT_W-1:0] pt;
        logic [ROOT_W-1:0] m;
        status_t           status;
    } p2_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] lng;
        logic signed [VALUE_WIDTH-1:0] side;
        status_t                       status;
    } p3_t;

    logic adv;
    logic [PIPE_LAT-1:0] v_reg;

    front_t fr;
    logic [ROOT_W-1:0] ml_root, pt_root, m_root;
    p1_t p1_head;
    p1_t p1_reg [SQRT_LAT];
    p2_t p2_head;
    p2_t p2_reg [DIV_LAT];
    p3_t p3_head;
    p3_t p3_reg [DIV_LAT];

    div_in_t dl_in, ds_in, do_in, de_in, dout_in;
    div_res_t dl_res, ds_res, do_res, de_res, dout_res;
    rc_in_t rc_in;
    rc_out_t rc_out;

    out_t res_next, res_reg;
    out_t m_data_reg, skid_reg;
    logic m_valid_reg, skid_valid_reg;

    assign adv     = !skid_valid_reg;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[PIPE_LAT-2:0], s_valid};
        end
    end

    pmosl_front u_front (
        .aclk (aclk),
        .en   (adv),
        .din  (s_data),
        .dout (fr)
    );

    pmosl_isqrt u_sqrt_ml (.aclk(aclk), .en(adv), .x(fr.ml2), .root(ml_root));
    pmosl_isqrt u_sqrt_pt (.aclk(aclk), .en(adv), .x(fr.pt2), .root(pt_root));
    pmosl_isqrt u_sqrt_m  (.aclk(aclk), .en(adv), .x(fr.mm2), .root(m_root));

    assign p1_head.nl     = fr.nl;
    assign p1_head.ns     = fr.ns;
    assign p1_head.no     = fr.no;
    assign p1_head.ne     = fr.ne;
    assign p1_head.status = fr.status;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg[0] <= p1_head;
            for (int i = 1; i < SQRT_LAT; i++) begin
                p1_reg[i] <= p1_reg[i-1];
            end
        end
    end

    assign dl_in.num = NUM_W'(p1_reg[SQRT_LAT-1].nl);
    assign dl_in.den = {ml_root, 1'b0};
    assign ds_in.num = NUM_W'(p1_reg[SQRT_LAT-1].ns);
    assign ds_in.den = {pt_root, 1'b0};
    assign do_in.num = NUM_W'(p1_reg[SQRT_LAT-1].no);
    assign do_in.den = {1'b0, pt_root};
    assign de_in.num = NUM_W'(p1_reg[SQRT_LAT-1].ne);
    assign de_in.den = {1'b0, ml_root};

    pmosl_div u_div_long (.aclk(aclk), .en(adv), .din(dl_in), .dout(dl_res));
    pmosl_div u_div_side (.aclk(aclk), .en(adv), .din(ds_in), .dout(ds_res));
    pmosl_div u_div_o    (.aclk(aclk), .en(adv), .din(do_in), .dout(do_res));
    pmosl_div u_div_e    (.aclk(aclk), .en(adv), .din(de_in), .dout(de_res));

    assign p2_head.ml     = ml_root;
    assign p2_head.pt     = pt_root;
    assign p2_head.m      = m_root;
    assign p2_head.status = p1_reg[SQRT_LAT-1].status;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_reg[0] <= p2_head;
            for (int i = 1; i < DIV_LAT; i++) begin
                p2_reg[i] <= p2_reg[i-1];
            end
        end
    end

    assign rc_in.lng    = dl_res;
    assign rc_in.side   = ds_res;
    assign rc_in.o      = do_res;
    assign rc_in.e      = de_res;
    assign rc_in.ml     = p2_reg[DIV_LAT-1].ml;
    assign rc_in.pt     = p2_reg[DIV_LAT-1].pt;
    assign rc_in.m      = p2_reg[DIV_LAT-1].m;
    assign rc_in.status = p2_reg[DIV_LAT-1].status;

    pmosl_recomb u_recomb (
        .aclk (aclk),
        .en   (adv),
        .din  (rc_in),
        .dout (rc_out)
    );

    assign dout_in.num = rc_out.num;
    assign dout_in.den = rc_out.den;

    pmosl_div u_div_out (.aclk(aclk), .en(adv), .din(dout_in), .dout(dout_res));

    assign p3_head.lng    = rc_out.lng;
    assign p3_head.side   = rc_out.side;
    assign p3_head.status = rc_out.status;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_reg[0] <= p3_head;
            for (int i = 1; i < DIV_LAT; i++) begin
                p3_reg[i] <= p3_reg[i-1];
            end
        end
    end

    always_comb begin
        res_next.status = p3_reg[DIV_LAT-1].status;
        case (p3_reg[DIV_LAT-1].status)
            STAT_OK: begin
                res_next.out_component  = sat_val(dout_res);
                res_next.side_component = p3_reg[DIV_LAT-1].side;
                res_next.long_component = p3_reg[DIV_LAT-1].lng;
            end
            STAT_LONG: begin
                res_next.out_component  = '0;
                res_next.side_component = '0;
                res_next.long_component = '0;
            end
            default: begin
                res_next.out_component  = '0;
                res_next.side_component = '0;
                res_next.long_component = p3_reg[DIV_LAT-1].lng;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_valid_reg && !m_ready) begin
            if (adv && v_reg[PIPE_LAT-1]) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            m_valid_reg    <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= adv && v_reg[PIPE_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid_reg && !m_ready) begin
            if (adv) begin
                skid_reg <= res_reg;
            end
        end else if (skid_valid_reg) begin
            m_data_reg <= skid_reg;
        end else if (adv) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[hdl/pmosl_checker.sv]
// ----------------------------------------------------------------------------
// Pair momentum port checker
// Checks the result channel of the top level over time, attached by bind.
// ----------------------------------------------------------------------------
module pmosl_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            m_valid,
    input logic            m_ready,
    input pmosl_pkg::out_t m_data
);
    import pmosl_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result transaction changed while stalled.");

    a_long_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STAT_LONG |->
            m_data.out_component == '0 && m_data.side_component == '0 &&
            m_data.long_component == '0)
        else $error("Superluminal pair carries nonzero components.");

    a_trans_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STAT_ZERO_PT || m_data.status == STAT_TRANS) |->
            m_data.out_component == '0 && m_data.side_component == '0)
        else $error("Degenerate pair carries nonzero out or side.");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

endmodule

bind pair_momentum_out_side_long pmosl_checker u_pmosl_checker (.*);

[bench/tb_pair_momentum_out_side_long.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pair momentum out/side/long testbench
// Drives particle pairs through the block with random gaps on both sides and
// checks every result against a behavioral predictor of the decomposition.
// A directed table covers extremes and each status code, then random pairs.
// ----------------------------------------------------------------------------
module tb_pair_momentum_out_side_long;
    import pmosl_pkg::*;

    localparam int N_RANDOM    = 640;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN       = 400;
    localparam int IN_W        = $bits(in_t);

    typedef struct {
        in_t  pair;
        logic has_result;
        out_t result;
    } vector_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    out_t pending_results[$];
    int   errors = 0;
    int   idle_cycles = 0;
    bit   stim_done = 1'b0;
    vector_t vectors[$];

    always #5 aclk = ~aclk;

    pair_momentum_out_side_long u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    function automatic logic [127:0] isqrt(input logic [127:0] x);
        logic [127:0] r, b;
        r = 0;
        b = 128'd1 << 126;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Truncating divide, saturated to [-lim-1, lim]; zero divisor gives zero.
    function automatic logic signed [127:0] trunc_div(input logic signed [127:0] n,
                                                      input logic signed [127:0] d,
                                                      input logic signed [127:0] lim);
        logic signed [127:0] q;
        if (d == 0) return 0;
        q = n / d;
        if (q > lim) q = lim;
        if (q < -lim - 1) q = -lim - 1;
        return q;
    endfunction

    function automatic out_t decompose(input in_t p);
        logic signed [127:0] d0, dx, dy, dz, se, sx, sy, sz, ml2, ml, pt2, pt, m;
        logic signed [127:0] o, e, lim, big;
        out_t r;
        lim = (128'sd1 <<< 31) - 1;
        big = (128'sd1 <<< 63) - 1;
        d0 = $signed({97'd0, p.a_energy}) - $signed({97'd0, p.b_energy});
        se = $signed({97'd0, p.a_energy}) + $signed({97'd0, p.b_energy});
        dx = 128'(p.a_px) - 128'(p.b_px);
        dy = 128'(p.a_py) - 128'(p.b_py);
        dz = 128'(p.a_pz) - 128'(p.b_pz);
        sx = 128'(p.a_px) + 128'(p.b_px);
        sy = 128'(p.a_py) + 128'(p.b_py);
        sz = 128'(p.a_pz) + 128'(p.b_pz);
        r = '0;
        if ((sz < 0 ? -sz : sz) >= se) begin
            r.status = STAT_LONG;
            return r;
        end
        ml2 = se * se - sz * sz;
        ml = isqrt(ml2);
        r.long_component = 32'(trunc_div(se * dz - sz * d0, 2 * ml, lim));
        pt2 = sx * sx + sy * sy;
        if (sx == 0 && sy == 0) begin
            r.status = STAT_ZERO_PT;
        end else if (pt2 >= ml2) begin
            r.status = STAT_TRANS;
        end else begin
            r.status = STAT_OK;
            pt = isqrt(pt2);
            m = isqrt(ml2 - pt2);
            r.side_component = 32'(trunc_div(dy * sx - dx * sy, 2 * pt, lim));
            o = trunc_div(dx * sx + dy * sy, pt, big);
            e = trunc_div(se * d0 - sz * dz, ml, big);
            r.out_component = 32'(trunc_div(ml * o - pt * e, 2 * m, lim));
        end
        return r;
    endfunction

    function automatic int short_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic in_t random_pair();
        in_t p;
        int mode;
        p = IN_W'({$urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom});
        mode = $urandom_range(0, 9);
        if (mode < 7) begin
            // Physical pairs: momenta small beside the energies.
            p.a_energy = 31'($urandom_range(32'h4000_0000, 32'h7fff_ffff));
            p.b_energy = 31'($urandom_range(32'h4000_0000, 32'h7fff_ffff));
            p.a_px = $signed($urandom) >>> $urandom_range(2, 20);
            p.a_py = $signed($urandom) >>> $urandom_range(2, 20);
            p.a_pz = $signed($urandom) >>> $urandom_range(2, 20);
            p.b_px = $signed($urandom) >>> $urandom_range(2, 20);
            p.b_py = $signed($urandom) >>> $urandom_range(2, 20);
            p.b_pz = $signed($urandom) >>> $urandom_range(2, 20);
            if (mode == 6) begin
                p.b_px = -p.a_px;
                p.b_py = -p.a_py;
            end
        end
        return p;
    endfunction

    function automatic vector_t row(input in_t p, input logic has, input out_t r);
        vector_t v;
        v.pair = p;
        v.has_result = has;
        v.result = r;
        return v;
    endfunction

    function automatic in_t make_pair(input logic [30:0] ae, input logic [31:0] ax, ay, az,
                                      input logic [30:0] be, input logic [31:0] bx, by, bz);
        in_t p;
        p = {ae, ax, ay, az, be, bx, by, bz};
        return p;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so back-to-back transactions need no gap.
    task automatic send(input in_t p, input out_t want);
        int g;
        g = short_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_data <= p;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(want);
        @(negedge aclk);
    endtask

    initial begin
        out_t zero_long, zero_pt;
        vector_t v;
        in_t p;
        zero_long = '0;
        zero_long.status = STAT_LONG;
        zero_pt = '0;
        zero_pt.status = STAT_ZERO_PT;
        vectors.push_back(row('0, 1'b1, zero_long));
        vectors.push_back(row(make_pair(31'h7fffffff, 0, 0, 0, 31'h7fffffff, 0, 0, 0),
                              1'b1, zero_pt));
        vectors.push_back(row(make_pair(31'h10000, 0, 0, 32'h10000, 31'h0, 0, 0, 0),
                              1'b1, zero_long));
        vectors.push_back(row(make_pair(31'h10000, 0, 0, 32'hffff0000, 31'h0, 0, 0, 0),
                              1'b1, zero_long));
        vectors.push_back(row(make_pair(31'h7fffffff, 32'h80000000, 32'h80000000,
                                        32'h80000000, 31'h7fffffff, 32'h80000000,
                                        32'h80000000, 32'h80000000), 1'b0, '0));
        vectors.push_back(row(make_pair(31'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                        32'h7fffffff, 31'h7fffffff, 32'h7fffffff,
                                        32'h7fffffff, 0), 1'b0, '0));
        vectors.push_back(row(make_pair(31'h7fffffff, 32'h7fffffff, 0, 0, 31'h0,
                                        32'h80000000, 0, 0), 1'b0, '0));
        vectors.push_back(row(make_pair(31'h100000, 32'h10000, 0, 0, 31'h100000,
                                        0, 32'h10000, 0), 1'b0, '0));
        vectors.push_back(row(make_pair(31'h7fffffff, 32'h1000, 32'hfffff000, 32'h7fffffff,
                                        31'h0, 32'hfffff000, 32'h1000, 32'h80000001),
                              1'b0, '0));
        vectors.push_back(row(make_pair(31'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0,
                                        31'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0),
                              1'b0, '0));
        vectors.push_back(row(make_pair(31'h7fffffff, 32'h10, 32'hfffffff0, 32'h55555555,
                                        31'h1, 32'hffffffff, 32'h1, 32'haaaaaaab), 1'b0, '0));
        vectors.push_back(row(make_pair(31'h7fffffff, 32'h7fffffff, 0, 0,
                                        31'h7fffffff, 32'h80000001, 0, 0), 1'b1, zero_pt));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (vectors[i]) begin
            v = vectors[i];
            if (v.has_result && decompose(v.pair) != v.result) begin
                $error("table row %0d: predictor disagrees with typed result", i);
                errors++;
            end
            send(v.pair, v.has_result ? v.result : decompose(v.pair));
        end
        repeat (N_RANDOM) begin
            p = random_pair();
            send(p, decompose(p));
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    always @(negedge aclk) begin
        if ($urandom_range(0, 49) == 0) begin
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            m_ready <= ~m_ready;
        end else if (!m_ready && $urandom_range(0, 5) != 0) begin
            m_ready <= m_ready;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        out_t want;
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no pair outstanding");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.out_component !== want.out_component) begin
                    $error("out_component expected %0d got %0d",
                           want.out_component, m_data.out_component);
                    errors++;
                end
                if (m_data.side_component !== want.side_component) begin
                    $error("side_component expected %0d got %0d",
                           want.side_component, m_data.side_component);
                    errors++;
                end
                if (m_data.long_component !== want.long_component) begin
                    $error("long_component expected %0d got %0d",
                           want.long_component, m_data.long_component);
                    errors++;
                end
                if (m_data.status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, m_data.status);
                    errors++;
                end
            end
        end
    end

    initial begin
        wait (stim_done && pending_results.size() == 0);
        repeat (DRAIN) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

endmodule
